// ===== hw/rtl/igs_pkg.sv =====
// Shared types, codes and sizes for the incidence matrix graph store.
package igs_pkg;

    // Default sizes of the store
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 64;

    // A listing stops after this many neighbours
    localparam int RESULT_LIMIT = 64;

    // Entries in the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Width of every vertex, edge and count field
    localparam int FIELD_W   = 7;
    localparam int CFG_IDX_W = 1;

    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [1:0]         t_mode;

    // Item kinds
    localparam t_mode MODE_CLEAR  = 2'd0;
    localparam t_mode MODE_ADD    = 2'd1;
    localparam t_mode MODE_DEGREE = 2'd2;
    localparam t_mode MODE_LIST   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT   = 1'd1;

    // Classified command handed from front to back
    typedef struct packed {
        t_mode  mode;
        logic   a_ok;       // vertex_a has a row
        logic   b_ok;       // vertex_b has a row
        t_field vtx_a;
        t_field vtx_b;
        t_field edge_idx;
    } t_cmd;

endpackage

// ===== hw/rtl/incidence_matrix_graph_store.sv =====
// Top level of the incidence matrix graph store: config registers, front, queue, back.
//
//  channel  | handshake          | beat
//  ---------+--------------------+---------------------------------------------------
//  input    | i_valid / o_ready  | i_mode, i_edge_index, i_vertex_a, i_vertex_b
//  result   | o_valid / i_ready  | o_neighbour_vertex, o_neighbour_valid,
//           |                    | o_degree_count, o_last
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
//  Back sequencer: one memory read and one write port. A listing scans one memory row
//  per cycle unless a held result stalls it, and skips the scan when the asked row is empty.
//  Adds with a bad edge index or no valid endpoint are dropped; a valid endpoint alone is still written.
//  After reset a clearing pass zeroes every row with o_ready low.
//  A two-entry queue lets input beats arrive while the back works; a held result
//  stalls the back only when a further result is ready to go out.
module incidence_matrix_graph_store import igs_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_mode                i_mode,
    input  t_field               i_edge_index,
    input  t_field               i_vertex_a,
    input  t_field               i_vertex_b,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_field               o_neighbour_vertex,
    output logic                 o_neighbour_valid,
    output t_field               o_degree_count,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_field               i_cfg_data
);

    t_field r_vertex_count;
    t_field r_edge_count;
    logic   init_busy;
    logic   q_full;
    logic   q_push;
    t_cmd   q_in;
    logic   q_valid;
    t_cmd   q_out;
    logic   q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= FIELD_W'(64);
            r_edge_count   <= FIELD_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                CFG_EDGE_COUNT:   r_edge_count   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    igs_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_edge_index (i_edge_index),
        .i_vertex_a   (i_vertex_a),
        .i_vertex_b   (i_vertex_b),
        .i_init_busy  (init_busy),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (q_in)
    );

    igs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    igs_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_vertex_count     (r_vertex_count),
        .i_edge_count       (r_edge_count),
        .i_q_valid          (q_valid),
        .i_q_data           (q_out),
        .o_q_pop            (q_pop),
        .o_init_busy        (init_busy),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_neighbour_vertex (o_neighbour_vertex),
        .o_neighbour_valid  (o_neighbour_valid),
        .o_degree_count     (o_degree_count),
        .o_last             (o_last)
    );

endmodule

// ===== hw/rtl/igs_queue.sv =====
// Short command queue that decouples the front from the back.
module igs_queue import igs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QCW-1:0]   r_count;
    logic [QAW-1:0]   n_wr;
    logic [QAW-1:0]   n_rd;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == QCW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer wrap
    always_comb begin
        n_wr = (r_wr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QAW'(1);
        n_rd = (r_rd == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QAW'(1);
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/igs_front.sv =====
// Input side: takes item beats, checks ranges and queues the work that matters.
module igs_front import igs_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic   i_valid,
    output logic   o_ready,
    input  t_mode  i_mode,
    input  t_field i_edge_index,
    input  t_field i_vertex_a,
    input  t_field i_vertex_b,
    input  logic   i_init_busy,
    input  logic   i_q_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = ((VW > FIELD_W) ? VW : FIELD_W) + 1;
    localparam int EW = FIELD_W + 1;

    logic a_ok;
    logic b_ok;
    logic e_ok;
    logic no_op;

    // Range checks on vertex and edge numbers
    always_comb begin
        a_ok  = (i_vertex_a != '0) && (CW'(i_vertex_a) <= CW'(MAX_VERTICES));
        b_ok  = (i_vertex_b != '0) && (CW'(i_vertex_b) <= CW'(MAX_VERTICES));
        e_ok  = (i_edge_index != '0) && (EW'(i_edge_index) <= EW'(MAX_EDGES));
        no_op = (i_mode == MODE_ADD) && (!e_ok || (!a_ok && !b_ok));
    end

    // Accept while the queue has room and the start-up clear is done
    assign o_ready = !i_q_full && !i_init_busy;
    assign o_push  = i_valid && o_ready && !no_op;

    always_comb begin
        o_cmd.mode     = i_mode;
        o_cmd.a_ok     = a_ok;
        o_cmd.b_ok     = b_ok;
        o_cmd.vtx_a    = i_vertex_a;
        o_cmd.vtx_b    = i_vertex_b;
        o_cmd.edge_idx = i_edge_index;
    end

endmodule

// ===== hw/rtl/igs_back.sv =====
// Execution side: incidence memory, command sequencer and result register.
module igs_back import igs_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_field i_vertex_count,
    input  t_field i_edge_count,
    input  logic   i_q_valid,
    input  t_cmd   i_q_data,
    output logic   o_q_pop,
    output logic   o_init_busy,
    output logic   o_valid,
    input  logic   i_ready,
    output t_field o_neighbour_vertex,
    output logic   o_neighbour_valid,
    output t_field o_degree_count,
    output logic   o_last
);

    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW  = ((VW > FIELD_W) ? VW : FIELD_W) + 1;
    localparam int EW  = MAX_EDGES;
    localparam int NG  = (EW + 7) / 8;
    localparam int GCW = 4;

    // Sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] ST_CLR     = 4'd1;
    localparam logic [ST_W-1:0] ST_ADD_RA  = 4'd2;
    localparam logic [ST_W-1:0] ST_ADD_WA  = 4'd3;
    localparam logic [ST_W-1:0] ST_ADD_RB  = 4'd4;
    localparam logic [ST_W-1:0] ST_ADD_WB  = 4'd5;
    localparam logic [ST_W-1:0] ST_DEG_RD  = 4'd6;
    localparam logic [ST_W-1:0] ST_DEG_GRP = 4'd7;
    localparam logic [ST_W-1:0] ST_DEG_SUM = 4'd8;
    localparam logic [ST_W-1:0] ST_LST_RD  = 4'd9;
    localparam logic [ST_W-1:0] ST_LST_ROW = 4'd10;
    localparam logic [ST_W-1:0] ST_SCAN    = 4'd11;
    localparam logic [ST_W-1:0] ST_END     = 4'd12;

    // Incidence memory, one row per vertex
    logic [EW-1:0]   r_mem [MAX_VERTICES];
    logic [EW-1:0]   r_rd_data;

    logic [ST_W-1:0] r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [VW-1:0]   r_clr, n_clr;
    logic            r_init, n_init;
    logic [EW-1:0]   r_arow, n_arow;
    logic [VW-1:0]   r_chk, n_chk;
    logic [6:0]      r_hits, n_hits;
    t_field          r_pend_vtx, n_pend_vtx;
    logic            r_pend_valid, n_pend_valid;
    logic [GCW-1:0]  r_grp [NG];
    logic [GCW-1:0]  grp_cnt [NG];
    logic            grp_en;

    logic            r_out_valid, n_out_valid;
    t_field          r_out_vtx, n_out_vtx;
    logic            r_out_nvalid, n_out_nvalid;
    t_field          r_out_deg, n_out_deg;
    logic            r_out_last, n_out_last;

    logic            rd_en;
    logic [VW-1:0]   rd_addr;
    logic            wr_en;
    logic [VW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;

    logic [VW-1:0]   row_a;
    logic [VW-1:0]   row_b;
    logic [EW-1:0]   edge_bit;
    logic [EW-1:0]   mask;
    logic [EW-1:0]   a_row_now;
    logic [CW-1:0]   vc_lim;
    logic            chk_last;
    logic            hit;
    logic            out_free;
    t_field          deg_sum;

    // Row numbers, edge one-hot, counted edge columns, scan bound
    always_comb begin
        row_a = VW'(CW'(r_cmd.vtx_a) - CW'(1));
        row_b = VW'(CW'(r_cmd.vtx_b) - CW'(1));
        for (int i = 0; i < EW; i++) begin
            edge_bit[i] = (r_cmd.edge_idx == FIELD_W'(i + 1));
            mask[i]     = ({1'b0, i_edge_count} > (FIELD_W + 1)'(i));
        end
        vc_lim    = (CW'(i_vertex_count) > CW'(MAX_VERTICES)) ?
                    CW'(MAX_VERTICES) : CW'(i_vertex_count);
        chk_last  = (CW'(r_chk) == (vc_lim - CW'(1)));
        hit       = |(r_rd_data & r_arow);
        a_row_now = r_cmd.a_ok ? (r_rd_data & mask) : '0;
        out_free  = !r_out_valid || i_ready;
    end

    // Degree: per-byte counts, then a sum of the bytes
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_cnt[g] = '0;
            for (int k = 0; k < 8; k++) begin
                if (g * 8 + k < EW) begin
                    grp_cnt[g] = grp_cnt[g] + GCW'(a_row_now[g * 8 + k]);
                end
            end
        end
        deg_sum = '0;
        for (int g = 0; g < NG; g++) begin
            deg_sum = deg_sum + FIELD_W'(r_grp[g]);
        end
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_clr        = r_clr;
        n_init       = r_init;
        n_arow       = r_arow;
        n_chk        = r_chk;
        n_hits       = r_hits;
        n_pend_vtx   = r_pend_vtx;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_vtx    = r_out_vtx;
        n_out_nvalid = r_out_nvalid;
        n_out_deg    = r_out_deg;
        n_out_last   = r_out_last;
        o_q_pop      = 1'b0;
        grp_en       = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = row_a;
        wr_en        = 1'b0;
        wr_addr      = row_a;
        wr_data      = r_rd_data | edge_bit;

        case (r_state)
            ST_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    n_cmd = i_q_data;
                    case (i_q_data.mode)
                        MODE_CLEAR:  n_state = ST_CLR;
                        MODE_ADD:    n_state = i_q_data.a_ok ? ST_ADD_RA : ST_ADD_RB;
                        MODE_DEGREE: n_state = ST_DEG_RD;
                        default:     n_state = ST_LST_RD;
                    endcase
                end
            end
            // One row zeroed per cycle
            ST_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                if (r_clr == VW'(MAX_VERTICES - 1)) begin
                    n_clr   = '0;
                    n_init  = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + VW'(1);
                end
            end
            // Read-modify-write of each in-range endpoint row
            ST_ADD_RA: begin
                rd_en   = 1'b1;
                n_state = ST_ADD_WA;
            end
            ST_ADD_WA: begin
                wr_en   = 1'b1;
                n_state = r_cmd.b_ok ? ST_ADD_RB : ST_IDLE;
            end
            ST_ADD_RB: begin
                rd_en   = 1'b1;
                rd_addr = row_b;
                n_state = ST_ADD_WB;
            end
            ST_ADD_WB: begin
                wr_en   = 1'b1;
                wr_addr = row_b;
                n_state = ST_IDLE;
            end
            ST_DEG_RD: begin
                rd_en   = r_cmd.a_ok;
                n_state = ST_DEG_GRP;
            end
            ST_DEG_GRP: begin
                grp_en  = 1'b1;
                n_state = ST_DEG_SUM;
            end
            ST_DEG_SUM: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_vtx    = '0;
                    n_out_nvalid = 1'b0;
                    n_out_deg    = deg_sum;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_LST_RD: begin
                rd_en   = r_cmd.a_ok;
                n_state = ST_LST_ROW;
            end
            // Latch the asked row and, unless it is empty or no vertices are counted, start reading vertex 1
            ST_LST_ROW: begin
                n_arow       = a_row_now;
                n_pend_valid = 1'b0;
                n_hits       = '0;
                n_chk        = '0;
                if ((a_row_now == '0) || (vc_lim == '0)) begin
                    n_state = ST_END;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_state = ST_SCAN;
                end
            end
            // r_rd_data holds row r_chk; one hit is held back to place last
            ST_SCAN: begin
                rd_addr = r_chk + VW'(1);
                if (!(hit && r_pend_valid && !out_free)) begin
                    if (hit) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_vtx    = r_pend_vtx;
                            n_out_nvalid = 1'b1;
                            n_out_deg    = '0;
                            n_out_last   = 1'b0;
                        end
                        n_pend_vtx   = FIELD_W'(CW'(r_chk) + CW'(1));
                        n_pend_valid = 1'b1;
                        n_hits       = r_hits + 7'd1;
                    end
                    if (chk_last || (hit && (r_hits == 7'(RESULT_LIMIT - 1)))) begin
                        n_state = ST_END;
                    end else begin
                        rd_en = 1'b1;
                        n_chk = r_chk + VW'(1);
                    end
                end
            end
            // Final beat of a listing, or the empty marker
            ST_END: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_vtx    = r_pend_valid ? r_pend_vtx : '0;
                    n_out_nvalid = r_pend_valid;
                    n_out_deg    = '0;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory ports, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_arow       <= n_arow;
        r_chk        <= n_chk;
        r_hits       <= n_hits;
        r_pend_vtx   <= n_pend_vtx;
        r_out_vtx    <= n_out_vtx;
        r_out_nvalid <= n_out_nvalid;
        r_out_deg    <= n_out_deg;
        r_out_last   <= n_out_last;
        if (grp_en) begin
            for (int g = 0; g < NG; g++) begin
                r_grp[g] <= grp_cnt[g];
            end
        end
    end

    // Control registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_clr        <= '0;
            r_init       <= 1'b1;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_init       <= n_init;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_init_busy        = r_init;
    assign o_valid            = r_out_valid;
    assign o_neighbour_vertex = r_out_vtx;
    assign o_neighbour_valid  = r_out_nvalid;
    assign o_degree_count     = r_out_deg;
    assign o_last             = r_out_last;

endmodule
